// ----- rtl/prmv_pkg.sv -----
// ----------------------------------------------------------------------------
// prmv_pkg
// Shared widths, defaults and codes for the per-channel running statistics.
// ----------------------------------------------------------------------------
`default_nettype none

package prmv_pkg;

  localparam int CHANNEL_COUNT_DEF = 16;
  localparam int SAMPLE_BITS_DEF   = 16;

  localparam int CHAN_W   = 4;
  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 32;
  localparam int VAR_W    = 48;
  localparam int EVT_W    = 32;

  // iterative divider: dividend covers the variance difference, divisor the count
  localparam int DIV_N_W  = VAR_W;
  localparam int DIV_D_W  = EVT_W;

  localparam logic FUNC_ACCUM = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/prmv_div.sv -----
// ----------------------------------------------------------------------------
// prmv_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module prmv_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [prmv_pkg::DIV_N_W-1:0] dividend,
  input  wire logic [prmv_pkg::DIV_D_W-1:0] divisor,
  output logic                              busy,
  output logic                              done,
  output logic [prmv_pkg::DIV_N_W-1:0]      quotient
);

  localparam int NW = prmv_pkg::DIV_N_W;
  localparam int DW = prmv_pkg::DIV_D_W;
  localparam int CW = $clog2(NW);

  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [CW-1:0] count;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem, quotient[NW-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= !start && busy && (count == CW'(NW - 1));
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CW'(NW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? DW'(trial - {1'b0, dsr}) : DW'(trial);
      quotient <= {quotient[NW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/prmv_stat_mem.sv -----
// ----------------------------------------------------------------------------
// prmv_stat_mem
// Per-channel mean and variance store with a registered read port and
// per-entry valid bits; an entry that is not valid reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module prmv_stat_mem #(
  parameter int DEPTH = prmv_pkg::CHANNEL_COUNT_DEF,
  parameter int AW    = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        clear,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic [prmv_pkg::MEAN_W-1:0]      rd_mean,
  output logic [prmv_pkg::VAR_W-1:0]       rd_var,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [prmv_pkg::MEAN_W-1:0] wr_mean,
  input  wire logic [prmv_pkg::VAR_W-1:0]  wr_var
);

  localparam int WW = prmv_pkg::MEAN_W + prmv_pkg::VAR_W;

  logic [WW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WW-1:0]    rd_word;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= {wr_mean, wr_var};
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_mean = rd_vld ? rd_word[WW-1:prmv_pkg::VAR_W] : '0;
  assign rd_var  = rd_vld ? rd_word[prmv_pkg::VAR_W-1:0] : '0;

endmodule

`default_nettype wire

// ----- rtl/per_channel_running_mean_variance.sv -----
// ----------------------------------------------------------------------------
// per_channel_running_mean_variance
// Running mean (Q16.16) and variance (Q32.16) per ADC channel with a shared
// event count.
// ----------------------------------------------------------------------------
// One item is processed at a time. An accumulate transfer reads the channel
// entry (S_READ), makes a pass through the shared bit-serial divider for the
// mean step (S_MDIV), forms the error (S_ERR), its square (S_SQ) and the
// variance set-up (S_VST), makes a second divider pass for the variance step
// (S_VDIV), both steps divided by the event count, and in S_DONE loads the
// result and writes back once the output register is free. The next transfer
// is taken when the state is back in idle after that load. A clear or an
// out-of-range channel goes straight to S_DONE and loads its result once the
// output register is free. A new item is taken as soon as the previous result
// sits in the output register, even before it is transferred. Clear takes
// effect at once; reset needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module per_channel_running_mean_variance #(
  parameter int CHANNEL_COUNT = prmv_pkg::CHANNEL_COUNT_DEF,
  parameter int SAMPLE_BITS   = prmv_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          func,
  input  wire logic [prmv_pkg::CHAN_W-1:0]   channel,
  input  wire logic [prmv_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                          event_start,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [prmv_pkg::CHAN_W-1:0]        out_channel,
  output logic [prmv_pkg::MEAN_W-1:0]        mean_value,
  output logic [prmv_pkg::VAR_W-1:0]         variance_value,
  output logic [prmv_pkg::EVT_W-1:0]         events_seen
);

  localparam int MW = prmv_pkg::MEAN_W;
  localparam int VW = prmv_pkg::VAR_W;
  localparam int EW = prmv_pkg::EVT_W;
  localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [prmv_pkg::SAMPLE_W-1:0] SMP_MASK =
    prmv_pkg::SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MDIV = 3'd2;
  localparam logic [2:0] S_ERR  = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_VST  = 3'd5;
  localparam logic [2:0] S_VDIV = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                   state;
  logic [EW-1:0]                n;
  logic [EW-1:0]                n_next;
  logic [prmv_pkg::CHAN_W-1:0]  chan;
  logic [MW-1:0]                x;
  logic                         res_zero;
  logic [MW-1:0]                mean_cur;
  logic [VW-1:0]                var_cur;
  logic [MW-1:0]                m;
  logic [VW-1:0]                v;
  logic [MW-1:0]                e;
  logic [VW-1:0]                sq;
  logic                         up;
  logic [63:0]                  sq_full;
  logic                         in_range;
  logic                         take;
  logic                         load_out;

  logic                         mem_clear;
  logic                         mem_rd_en;
  logic                         mem_we;
  logic [MW-1:0]                rd_mean;
  logic [VW-1:0]                rd_var;

  logic                         div_start;
  logic [prmv_pkg::DIV_N_W-1:0] div_dividend;
  logic                         div_busy;
  logic                         div_done;
  logic [prmv_pkg::DIV_N_W-1:0] quotient;

  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;
  assign in_range = 32'(channel) < CHANNEL_COUNT;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  assign n_next = ((event_start || n == '0) && n != '1) ? n + 1'b1 : n;

  assign mem_clear = take && (func == prmv_pkg::FUNC_CLEAR);
  assign mem_rd_en = take && (func == prmv_pkg::FUNC_ACCUM) && in_range;
  assign mem_we    = load_out && !res_zero;

  assign sq_full = 64'(e) * 64'(e);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    if (state == S_READ) begin
      div_start    = 1'b1;
      div_dividend = prmv_pkg::DIV_N_W'((x >= rd_mean) ? x - rd_mean : rd_mean - x);
    end else if (state == S_VST) begin
      div_start    = 1'b1;
      div_dividend = (sq >= var_cur) ? sq - var_cur : var_cur - sq;
    end
  end

  prmv_stat_mem #(
    .DEPTH (CHANNEL_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .clear   (mem_clear),
    .rd_en   (mem_rd_en),
    .rd_addr (AW'(channel)),
    .rd_mean (rd_mean),
    .rd_var  (rd_var),
    .we      (mem_we),
    .wr_addr (AW'(chan)),
    .wr_mean (m),
    .wr_var  (v)
  );

  prmv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (func == prmv_pkg::FUNC_CLEAR) begin
              n     <= '0;
              state <= S_DONE;
            end else begin
              n     <= n_next;
              state <= in_range ? S_READ : S_DONE;
            end
          end
        end
        S_READ: state <= S_MDIV;
        S_MDIV: begin
          if (div_done) begin
            state <= S_ERR;
          end
        end
        S_ERR:  state <= S_SQ;
        S_SQ:   state <= S_VST;
        S_VST:  state <= S_VDIV;
        S_VDIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      chan     <= (func == prmv_pkg::FUNC_CLEAR) ? '0 : channel;
      x        <= {sample & SMP_MASK, 16'h0000};
      res_zero <= (func == prmv_pkg::FUNC_CLEAR) || !in_range;
    end
    if (state == S_READ) begin
      mean_cur <= rd_mean;
      var_cur  <= rd_var;
      up       <= x >= rd_mean;
    end
    if (state == S_MDIV && div_done) begin
      m <= up ? mean_cur + MW'(quotient) : mean_cur - MW'(quotient);
    end
    if (state == S_ERR) begin
      e <= (x >= m) ? x - m : m - x;
    end
    if (state == S_SQ) begin
      sq <= sq_full[63:16];
    end
    if (state == S_VST) begin
      up <= sq >= var_cur;
    end
    if (state == S_VDIV && div_done) begin
      v <= up ? var_cur + quotient : var_cur - quotient;
    end
    if (load_out) begin
      out_channel    <= chan;
      mean_value     <= res_zero ? '0 : m;
      variance_value <= res_zero ? '0 : v;
      events_seen    <= n;
    end
  end

`ifndef NO_ASSERTIONS
  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_MDIV || state == S_VDIV) |-> n != '0)
    else $error("division by zero event count");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> 32'(chan) < CHANNEL_COUNT)
    else $error("store written for channel out of range");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_MDIV && !div_busy && !div_done) |-> $past(div_start))
    else $error("mean division lost");
`endif

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives per_channel_running_mean_variance with a short table of hand-picked
// transfers, then about eleven hundred random ones under three idle mixes.
// Each result is checked field by field against the typed rows' values or an
// in-bench fixed-point model of per-channel mean, variance and shared count.
// ----------------------------------------------------------------------------

module testbench;

  localparam int CHAN_W            = prmv_pkg::CHAN_W;
  localparam int SAMPLE_W          = prmv_pkg::SAMPLE_W;
  localparam int MEAN_W            = prmv_pkg::MEAN_W;
  localparam int VAR_W             = prmv_pkg::VAR_W;
  localparam int EVT_W             = prmv_pkg::EVT_W;
  localparam int CHANNEL_COUNT_DEF = prmv_pkg::CHANNEL_COUNT_DEF;
  localparam int SAMPLE_BITS_DEF   = prmv_pkg::SAMPLE_BITS_DEF;

  localparam int QUIET_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int ITEMS_PER_MIX = 380;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS_DEF) - 1);

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  vari;
    logic [EVT_W-1:0]  evts;
  } stats_t;

  typedef struct packed {
    logic                typed;
    logic                op;
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] smp;
    logic                start;
    stats_t              want;
  } row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic                func;
  logic [CHAN_W-1:0]   channel;
  logic [SAMPLE_W-1:0] sample;
  logic                event_start;
  logic                out_valid;
  logic                out_ready;
  logic [CHAN_W-1:0]   out_channel;
  logic [MEAN_W-1:0]   mean_value;
  logic [VAR_W-1:0]    variance_value;
  logic [EVT_W-1:0]    events_seen;

  logic   row_typed;
  stats_t row_want;
  logic   hold_req;
  int     src_idle_pct;
  int     sink_idle_pct;
  int     quiet;
  int     n_items;
  int     n_clears;
  int     n_checked;
  int     n_errors;

  logic [EVT_W-1:0]  evt_count;
  logic [MEAN_W-1:0] mean_mem [CHANNEL_COUNT_DEF];
  logic [VAR_W-1:0]  var_mem [CHANNEL_COUNT_DEF];
  stats_t            stats_due [$];

  row_t dir_rows [22] = '{
    '{1'b1, prmv_pkg::FUNC_ACCUM, 4'd0,  16'hFFFF, 1'b0, '{4'd0,  32'hFFFF0000, 48'h0, 32'd1}},
    '{1'b1, prmv_pkg::FUNC_ACCUM, 4'd15, 16'h0000, 1'b1, '{4'd15, 32'h0, 48'h0, 32'd2}},
    '{1'b0, prmv_pkg::FUNC_ACCUM, 4'd0,  16'h0000, 1'b0, '0},
    '{1'b0, prmv_pkg::FUNC_ACCUM, 4'd0,  16'hFFFF, 1'b1, '0},
    '{1'b1, prmv_pkg::FUNC_CLEAR, 4'd0,  16'h0000, 1'b0, '0},
    '{1'b1, prmv_pkg::FUNC_ACCUM, 4'd7,  16'h1234, 1'b1, '{4'd7,  32'h12340000, 48'h0, 32'd1}},
    '{1'b1, prmv_pkg::FUNC_ACCUM, 4'd7,  16'h1234, 1'b0, '{4'd7,  32'h12340000, 48'h0, 32'd1}},
    '{1'b0, prmv_pkg::FUNC_ACCUM, 4'd7,  16'hFFFF, 1'b1, '0},
    '{1'b0, prmv_pkg::FUNC_ACCUM, 4'd7,  16'h0000, 1'b1, '0},
    '{1'b0, prmv_pkg::FUNC_ACCUM, 4'd3,  16'h5555, 1'b0, '0},
    '{1'b0, prmv_pkg::FUNC_ACCUM, 4'd12, 16'hAAAA, 1'b1, '0},
    '{1'b0, prmv_pkg::FUNC_ACCUM, 4'd8,  16'h8000, 1'b0, '0},
    '{1'b0, prmv_pkg::FUNC_ACCUM, 4'd1,  16'h0001, 1'b1, '0},
    '{1'b0, prmv_pkg::FUNC_ACCUM, 4'd14, 16'h7FFF, 1'b0, '0},
    '{1'b1, prmv_pkg::FUNC_CLEAR, 4'd9,  16'hFFFF, 1'b1, '0},
    '{1'b1, prmv_pkg::FUNC_CLEAR, 4'd0,  16'h0000, 1'b0, '0},
    '{1'b1, prmv_pkg::FUNC_ACCUM, 4'd0,  16'h0000, 1'b0, '{4'd0,  32'h0, 48'h0, 32'd1}},
    '{1'b1, prmv_pkg::FUNC_ACCUM, 4'd0,  16'hFFFF, 1'b0, '{4'd0,  32'hFFFF0000, 48'h0, 32'd1}},
    '{1'b0, prmv_pkg::FUNC_ACCUM, 4'd0,  16'h0000, 1'b1, '0},
    '{1'b0, prmv_pkg::FUNC_ACCUM, 4'd0,  16'h0000, 1'b0, '0},
    '{1'b0, prmv_pkg::FUNC_ACCUM, 4'd2,  16'hFFFF, 1'b1, '0},
    '{1'b0, prmv_pkg::FUNC_ACCUM, 4'd10, 16'h0000, 1'b0, '0}
  };

  per_channel_running_mean_variance DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .channel        (channel),
    .sample         (sample),
    .event_start    (event_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .mean_value     (mean_value),
    .variance_value (variance_value),
    .events_seen    (events_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] step_toward(input logic [63:0] cur,
                                              input logic [63:0] target,
                                              input logic [63:0] n);
    if (target >= cur) return cur + (target - cur) / n;
    return cur - (cur - target) / n;
  endfunction

  function automatic stats_t update_stats(input logic op, input logic [CHAN_W-1:0] ch,
                                          input logic [SAMPLE_W-1:0] smp,
                                          input logic start);
    logic [63:0] x;
    logic [63:0] m;
    logic [63:0] e;
    logic [63:0] sq;
    logic [63:0] v;
    stats_t      r;
    r = '0;
    if (op == prmv_pkg::FUNC_CLEAR) begin
      evt_count = '0;
      foreach (mean_mem[i]) begin
        mean_mem[i] = '0;
        var_mem[i]  = '0;
      end
      return r;
    end
    if ((start || evt_count == '0) && evt_count != '1) evt_count = evt_count + 1'b1;
    if (int'(ch) < CHANNEL_COUNT_DEF) begin
      x  = 64'(smp & SAMPLE_MASK) << 16;
      m  = step_toward(64'(mean_mem[ch]), x, 64'(evt_count)) & 64'hFFFF_FFFF;
      e  = (x >= m) ? (x - m) : (m - x);
      sq = (e * e) >> 16;
      v  = step_toward(64'(var_mem[ch]), sq, 64'(evt_count)) & 64'hFFFF_FFFF_FFFF;
      mean_mem[ch] = m[MEAN_W-1:0];
      var_mem[ch]  = v[VAR_W-1:0];
      r.mean = m[MEAN_W-1:0];
      r.vari = v[VAR_W-1:0];
    end
    r.chan = ch;
    r.evts = evt_count;
    return r;
  endfunction

  task automatic offer(input logic op, input logic [CHAN_W-1:0] ch,
                       input logic [SAMPLE_W-1:0] smp, input logic start,
                       input logic typed, input stats_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    func        <= op;
    channel     <= ch;
    sample      <= smp;
    event_start <= start;
    row_typed   <= typed;
    row_want    <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic offer_random();
    logic                op;
    logic [CHAN_W-1:0]   ch;
    logic [SAMPLE_W-1:0] smp;
    logic                start;
    int                  pick;
    op    = ($urandom_range(0, 99) < 3) ? prmv_pkg::FUNC_CLEAR : prmv_pkg::FUNC_ACCUM;
    ch    = CHAN_W'($urandom_range(0, CHANNEL_COUNT_DEF - 1));
    pick  = $urandom_range(0, 9);
    // cluster four in ten samples around a per-channel pedestal
    if (pick == 0)     smp = '0;
    else if (pick == 1) smp = '1;
    else if (pick < 6) smp = SAMPLE_W'(16'h0F00 * ch + $urandom_range(0, 63));
    else               smp = SAMPLE_W'($urandom);
    start = ($urandom_range(0, 3) == 0);
    offer(op, ch, smp, start, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (stats_due.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic run_mix(input int src_pct, input int sink_pct, input logic with_hold);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int i = 0; i < ITEMS_PER_MIX; i++) begin
      if (with_hold && i == ITEMS_PER_MIX / 2) hold_req = 1'b1;
      offer_random();
    end
    drain();
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    stats_t got;
    stats_t want;
    logic   moved;
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        moved = 1'b1;
        want  = update_stats(func, channel, sample, event_start);
        stats_due.insert(stats_due.size(), row_typed ? row_want : want);
        n_items++;
        if (func == prmv_pkg::FUNC_CLEAR) n_clears++;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        got   = {out_channel, mean_value, variance_value, events_seen};
        if (stats_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result: chan %0d mean %h var %h events %0d",
                     got.chan, got.mean, got.vari, got.evts);
        end else begin
          want = stats_due.pop_front();
          n_checked++;
          if (got.chan !== want.chan || got.mean !== want.mean ||
              got.vari !== want.vari || got.evts !== want.evts) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("mismatch on result %0d: expected chan %0d mean %h var %h events %0d",
                       n_checked, want.chan, want.mean, want.vari, want.evts);
              $display("  got chan %0d mean %h var %h events %0d",
                       got.chan, got.mean, got.vari, got.evts);
            end
          end
        end
      end
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, stats_due.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    func          = prmv_pkg::FUNC_ACCUM;
    channel       = '0;
    sample        = '0;
    event_start   = 1'b0;
    row_typed     = 1'b0;
    row_want      = '0;
    hold_req      = 1'b0;
    src_idle_pct  = 37;
    sink_idle_pct = 77;
    quiet         = 0;
    n_items       = 0;
    n_clears      = 0;
    n_checked     = 0;
    n_errors      = 0;
    void'(update_stats(prmv_pkg::FUNC_CLEAR, '0, '0, 1'b0));
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i])
      offer(dir_rows[i].op, dir_rows[i].chan, dir_rows[i].smp, dir_rows[i].start,
            dir_rows[i].typed, dir_rows[i].want);
    run_mix(37, 77, 1'b1);
    run_mix(77, 37, 1'b0);
    run_mix(0, 0, 1'b0);
    repeat (150) @(negedge clk);
    $display("Run covered %0d transfers in, %0d of them clears, and %0d results checked.",
             n_items, n_clears, n_checked);
    $display("Idle mixes 37/77, 77/37 and none, plus a %0d-cycle receiver hold-off.",
             HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
